// ===== sv/csvt_pkg.sv =====
// ----------------------------------------------------------------------------
// csvt_pkg
// Types and constants shared by the CSV byte tokenizer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package csvt_pkg;

   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;

   // Result queue depth and the width of its fill count.
   localparam int QDEPTH = 3;
   localparam int QCW    = 2;

   typedef enum logic [2:0] {
      MODE_NORMAL     = 3'd0,
      MODE_QUOTED     = 3'd1,
      MODE_QUOTE_SEEN = 3'd2,
      MODE_CR_SEEN    = 3'd3,
      MODE_ERROR      = 3'd4
   } csvt_mode_type;

   typedef enum logic [1:0] {
      KIND_BYTE      = 2'd0,
      KIND_FIELD_END = 2'd1,
      KIND_ROW_END   = 2'd2,
      KIND_ERROR     = 2'd3
   } csvt_kind_type;

   typedef struct packed {
      csvt_kind_type kind;
      logic [7:0]    field_byte;
      logic          last_of_run;
   } csvt_result_type;

   // Up to two results caused by one request, in order.
   typedef struct packed {
      logic [1:0]      count;
      csvt_result_type r0;
      csvt_result_type r1;
   } csvt_pair_type;

   typedef struct packed {
      logic [QCW-1:0] count;
   } csvt_qstat_type;

endpackage

`default_nettype wire

// ===== sv/csvt_decode.sv =====
// ----------------------------------------------------------------------------
// csvt_decode
// Tokenizer state machine: turns one registered request into up to two
// results and advances the parser state when the request is consumed.
// ----------------------------------------------------------------------------
`default_nettype none

module csvt_decode import csvt_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          step,
   input  wire logic [7:0]    text_byte,
   input  wire logic          end_of_text,
   output csvt_pair_type      pair
);

   csvt_mode_type mode_ff, mode_in, mode_mid;
   logic          row_open_ff, row_open_in, row_open_mid;

   // Byte part of the transition.
   always_comb begin
      mode_mid     = mode_ff;
      row_open_mid = row_open_ff;
      unique case (mode_ff)
         MODE_QUOTED: begin
            if (text_byte == CH_QUOTE) mode_mid = MODE_QUOTE_SEEN;
         end
         MODE_QUOTE_SEEN: begin
            if (text_byte == CH_QUOTE) begin
               mode_mid = MODE_QUOTED;
            end else if (text_byte == CH_COMMA) begin
               mode_mid = MODE_NORMAL;
            end else if (text_byte == CH_CR) begin
               mode_mid = MODE_CR_SEEN;
            end else begin
               mode_mid = MODE_ERROR;
            end
         end
         MODE_CR_SEEN: begin
            if (text_byte == CH_LF) begin
               mode_mid     = MODE_NORMAL;
               row_open_mid = 1'b0;
            end else begin
               mode_mid = MODE_ERROR;
            end
         end
         MODE_ERROR: begin
            mode_mid = MODE_ERROR;
         end
         default: begin
            mode_mid = MODE_NORMAL;
            if (text_byte == CH_QUOTE) begin
               mode_mid     = MODE_QUOTED;
               row_open_mid = 1'b1;
            end else if (text_byte == CH_CR) begin
               mode_mid = MODE_CR_SEEN;
            end else begin
               row_open_mid = 1'b1;
            end
         end
      endcase
   end

   // Next state: the end of the text returns everything to reset.
   always_comb begin
      if (end_of_text) begin
         mode_in     = MODE_NORMAL;
         row_open_in = 1'b0;
      end else begin
         mode_in     = mode_mid;
         row_open_in = row_open_mid;
      end
   end

   // Outputs.
   always_comb begin
      logic          b_v, e_v;
      csvt_kind_type b_kind, e_kind;
      logic [7:0]    b_byte;
      b_v    = 1'b0;
      b_kind = KIND_BYTE;
      b_byte = 8'h00;
      e_v    = 1'b0;
      e_kind = KIND_ERROR;
      unique case (mode_ff)
         MODE_QUOTED: begin
            if (text_byte != CH_QUOTE) begin
               b_v    = 1'b1;
               b_byte = text_byte;
            end
         end
         MODE_QUOTE_SEEN: begin
            if (text_byte == CH_QUOTE) begin
               b_v    = 1'b1;
               b_byte = CH_QUOTE;
            end else if (text_byte == CH_COMMA) begin
               b_v    = 1'b1;
               b_kind = KIND_FIELD_END;
            end else if (text_byte != CH_CR) begin
               b_v    = 1'b1;
               b_kind = KIND_ERROR;
            end
         end
         MODE_CR_SEEN: begin
            b_v    = 1'b1;
            b_kind = (text_byte == CH_LF) ? KIND_ROW_END : KIND_ERROR;
         end
         MODE_ERROR: begin
            b_v = 1'b0;
         end
         default: begin
            if (text_byte == CH_COMMA) begin
               b_v    = 1'b1;
               b_kind = KIND_FIELD_END;
            end else if (text_byte != CH_QUOTE && text_byte != CH_CR) begin
               b_v    = 1'b1;
               b_byte = text_byte;
            end
         end
      endcase

      if (end_of_text) begin
         unique case (mode_mid)
            MODE_QUOTED, MODE_CR_SEEN: begin
               e_v    = 1'b1;
               e_kind = KIND_ERROR;
            end
            MODE_QUOTE_SEEN: begin
               e_v    = 1'b1;
               e_kind = KIND_ROW_END;
            end
            MODE_ERROR: begin
               e_v = 1'b0;
            end
            default: begin
               e_v    = row_open_mid;
               e_kind = KIND_ROW_END;
            end
         endcase
      end

      pair.count = {1'b0, b_v} + {1'b0, e_v};
      if (b_v) begin
         pair.r0 = '{kind: b_kind, field_byte: b_byte, last_of_run: !e_v};
         pair.r1 = '{kind: e_kind, field_byte: 8'h00, last_of_run: 1'b1};
      end else begin
         pair.r0 = '{kind: e_kind, field_byte: 8'h00, last_of_run: 1'b1};
         pair.r1 = '{kind: e_kind, field_byte: 8'h00, last_of_run: 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_NORMAL;
         row_open_ff <= 1'b0;
      end else if (step) begin
         mode_ff     <= mode_in;
         row_open_ff <= row_open_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/csvt_rsp_queue.sv =====
// ----------------------------------------------------------------------------
// csvt_rsp_queue
// Shifting result queue: takes up to two results per cycle and presents
// the oldest one on the response channel from a fixed head register.
// ----------------------------------------------------------------------------
`default_nettype none

module csvt_rsp_queue import csvt_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire csvt_pair_type pair,
   input  wire logic          pop,
   output csvt_result_type    head,
   output logic               head_valid,
   output csvt_qstat_type     stat
);

   csvt_result_type q_ff [QDEPTH];
   csvt_result_type q_in [QDEPTH];
   logic [QCW-1:0]  cnt_ff, cnt_in;
   logic [QCW-1:0]  base;

   assign base = cnt_ff - {{(QCW-1){1'b0}}, pop};

   always_comb begin
      for (int i = 0; i < QDEPTH; i++) begin
         csvt_result_type src;
         if (pop && i < QDEPTH - 1) begin
            src = q_ff[(i + 1) % QDEPTH];
         end else begin
            src = q_ff[i];
         end
         if (QCW'(i) < base || !push) begin
            q_in[i] = src;
         end else if (QCW'(i) == base) begin
            q_in[i] = pair.r0;
         end else begin
            q_in[i] = pair.r1;
         end
      end
      cnt_in = base + (push ? QCW'(pair.count) : '0);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QDEPTH; i++) q_ff[i] <= q_in[i];
   end

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= '0;
      else       cnt_ff <= cnt_in;
   end

   assign head       = q_ff[0];
   assign head_valid = (cnt_ff != '0);
   assign stat.count = cnt_ff;

endmodule

`default_nettype wire

// ===== sv/csv_byte_tokenizer.sv =====
// ----------------------------------------------------------------------------
// csv_byte_tokenizer
// Streaming CSV tokenizer: one text byte per request, field bytes and
// field-end, row-end and error marks out.
// ----------------------------------------------------------------------------
// The first result of a request passes from the input register to the result
// queue head before it is presented; the input register holds the request
// while the queue lacks room for its results.
// Throughput: one request per cycle while the result queue has room; a request
// with two results presents them in turn, absorbed by a three-entry result queue.
// Reset clears the parser state, the input register valid and the queue.
`default_nettype none

module csv_byte_tokenizer import csvt_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_text_byte,
   input  wire logic       req_end_of_text,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [1:0]      rsp_kind,
   output logic [7:0]      rsp_field_byte,
   output logic            rsp_last_of_run
);

   logic            in_v_ff, in_v_in;
   logic [7:0]      in_byte_ff;
   logic            in_eot_ff;
   logic            move, pop;
   logic [QCW:0]    room_need;
   csvt_pair_type   pair;
   csvt_result_type head;
   csvt_qstat_type  stat;

   csvt_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .step        (move),
      .text_byte   (in_byte_ff),
      .end_of_text (in_eot_ff),
      .pair        (pair)
   );

   assign pop = rsp_valid && rsp_ready;

   // The registered request moves on once its results fit after this pop.
   assign room_need = {1'b0, stat.count} - {{QCW{1'b0}}, pop} + (QCW+1)'(pair.count);
   assign move      = in_v_ff && (room_need <= (QCW+1)'(QDEPTH));
   assign req_ready = !in_v_ff || move;

   always_comb begin
      in_v_in = in_v_ff;
      if (req_valid && req_ready) in_v_in = 1'b1;
      else if (move)              in_v_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) in_v_ff <= 1'b0;
      else       in_v_ff <= in_v_in;
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_text_byte;
         in_eot_ff  <= req_end_of_text;
      end
   end

   csvt_rsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (move),
      .pair       (pair),
      .pop        (pop),
      .head       (head),
      .head_valid (rsp_valid),
      .stat       (stat)
   );

   assign rsp_kind        = head.kind;
   assign rsp_field_byte  = head.field_byte;
   assign rsp_last_of_run = head.last_of_run;

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      stat.count <= QCW'(QDEPTH))
      else $error("result queue overfilled");

   a_no_lost_request: assert property (@(posedge clock) disable iff (reset)
      (in_v_ff && !move) |=> (in_v_ff && $stable(in_byte_ff) && $stable(in_eot_ff)))
      else $error("stalled input register changed");

   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> (!rsp_valid && !in_v_ff))
      else $error("activity right after reset");

endmodule

`default_nettype wire
